### src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define PLC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

// checked at every edge, reset included
`define PLC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

### src/plc_pkg.sv
// Shared types, constants and the exp2 root table for the power-law unit.
// No dependencies.
package plc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int LOG_FRAC  = 28;
  localparam int MANT_FRAC = 30;
  localparam int EXP_FRAC  = 12;
  localparam int T_W       = 63 - FRAC_BITS;
  localparam int P_W       = $clog2(T_W);
  localparam logic [30:0] OUT_MAX = 31'h7FFF_FFFF;

  localparam logic [1:0] REG_GAMMA    = 2'd0;
  localparam logic [1:0] REG_INV_EXP  = 2'd1;
  localparam logic [1:0] REG_PEAK     = 2'd2;
  localparam logic [1:0] REG_INV_PEAK = 2'd3;

  typedef struct packed {
    logic                 dir;
    logic                 zero;
    logic signed [P_W:0]  p_off;
  } log_side_t;

  typedef struct packed {
    logic               dir;
    logic               kill;
    logic signed [10:0] ip;
  } exp_side_t;

  typedef logic [31:0] root_arr_t [LOG_FRAC];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] bitv;
    logic [63:0] w;
    r = '0;
    w = v;
    bitv = 64'd1 << 62;
    while (bitv > w) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (w >= r + bitv) begin
        w = w - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic root_arr_t build_roots();
    root_arr_t   tbl;
    logic [63:0] r;
    r = isqrt64(64'd1 << 61);
    for (int k = 0; k < LOG_FRAC; k++) begin
      tbl[k] = r[31:0];
      r = isqrt64(r << MANT_FRAC);
    end
    return tbl;
  endfunction

  localparam root_arr_t ROOTS = build_roots();

endpackage

### src/plc_log_cell.sv
// One log2 fraction-bit cell: squares the Q1.30 mantissa and emits one bit.
// Depends on plc_pkg.
module plc_log_cell
  import plc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                vld_i,
  input  logic [30:0]         m_i,
  input  logic [LOG_FRAC-1:0] frac_i,
  input  log_side_t           side_i,
  output logic                vld_o,
  output logic [30:0]         m_o,
  output logic [LOG_FRAC-1:0] frac_o,
  output log_side_t           side_o
);

  logic [61:0] sq;
  logic [31:0] q;

  always_comb begin
    sq = 62'(m_i) * 62'(m_i);
    q  = sq[61:30];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_o    <= q[31] ? q[31:1] : q[30:0];
      frac_o <= {frac_i[LOG_FRAC-2:0], q[31]};
      side_o <= side_i;
    end
  end

endmodule

### src/plc_exp_cell.sv
// One exp2 cell: multiplies the mantissa by its root when its fraction bit is set.
// Depends on plc_pkg.
module plc_exp_cell
  import plc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [31:0]         root,
  input  logic                vld_i,
  input  logic [31:0]         m_i,
  input  logic [LOG_FRAC-1:0] f_i,
  input  exp_side_t           side_i,
  output logic                vld_o,
  output logic [31:0]         m_o,
  output logic [LOG_FRAC-1:0] f_o,
  output exp_side_t           side_o
);

  logic [63:0] prod;

  always_comb begin
    prod = 64'(m_i) * 64'(root);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (en) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_o    <= f_i[LOG_FRAC-1] ? prod[61:30] : m_i;
      f_o    <= {f_i[LOG_FRAC-2:0], 1'b0};
      side_o <= side_i;
    end
  end

endmodule

### src/power_law_transfer_unit.sv
// Power-law transfer unit: pre-scale, normalize, 28 log cells, exponent
// multiply, 28 exp cells, scale and saturate. Depends on plc_pkg and the cells.
// 61 register stages; throughput one item per cycle unless the output stalls.
// The whole pipe advances when the output register is empty or being taken.
// Reset (rst, synchronous) clears all valid bits and loads the register defaults.
module power_law_transfer_unit
  import plc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        direction,
  input  logic [31:0] sample_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] sample_out,
  output logic        saturated,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [15:0] gamma_exponent;
  logic [15:0] inverse_exponent;
  logic [31:0] peak_scale;
  logic [31:0] inverse_peak_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_exponent     <= 16'd9011;
      inverse_exponent   <= 16'd1862;
      peak_scale         <= 32'd65536;
      inverse_peak_scale <= 32'd65536;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAMMA:    gamma_exponent     <= cfg_data[15:0];
        REG_INV_EXP:  inverse_exponent   <= cfg_data[15:0];
        REG_PEAK:     peak_scale         <= cfg_data;
        REG_INV_PEAK: inverse_peak_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en && !rst;

  // stage A: clamp and inverse pre-scale
  logic [30:0]  x;
  logic [62:0]  pre;
  logic         a_vld;
  logic         a_dir;
  logic [T_W-1:0] a_t;

  always_comb begin
    x   = sample_in[31] ? 31'd0 : sample_in[30:0];
    pre = 63'(x) * 63'(inverse_peak_scale);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dir <= direction;
      a_t   <= direction ? pre[62:FRAC_BITS] : T_W'(x);
    end
  end

  // stage B: normalize to Q1.30
  logic [P_W-1:0] p;
  logic [30:0]    nm;

  always_comb begin
    p = '0;
    for (int i = 0; i < T_W; i++) begin
      if (a_t[i]) p = P_W'(i);
    end
    if (p <= P_W'(MANT_FRAC)) nm = 31'(a_t << (P_W'(MANT_FRAC) - p));
    else                      nm = 31'(a_t >> (p - P_W'(MANT_FRAC)));
  end

  logic                l_vld  [LOG_FRAC+1];
  logic [30:0]         l_m    [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] l_frac [LOG_FRAC+1];
  log_side_t           l_side [LOG_FRAC+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      l_vld[0] <= 1'b0;
    end else if (en) begin
      l_vld[0] <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l_m[0]          <= nm;
      l_frac[0]       <= '0;
      l_side[0].dir   <= a_dir;
      l_side[0].zero  <= (a_t == '0);
      l_side[0].p_off <= $signed({1'b0, p}) - (P_W+1)'(FRAC_BITS);
    end
  end

  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_log
    plc_log_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vld_i(l_vld[k]), .m_i(l_m[k]), .frac_i(l_frac[k]), .side_i(l_side[k]),
      .vld_o(l_vld[k+1]), .m_o(l_m[k+1]), .frac_o(l_frac[k+1]), .side_o(l_side[k+1])
    );
  end

  // stage C: log times exponent
  log_side_t          ls;
  logic [15:0]        e;
  logic signed [LOG_FRAC+P_W:0] lg;
  logic signed [LOG_FRAC+P_W+17:0] lp;
  logic signed [LOG_FRAC+P_W+17-EXP_FRAC:0] y;

  always_comb begin
    ls = l_side[LOG_FRAC];
    e  = ls.dir ? inverse_exponent : gamma_exponent;
    lg = $signed({ls.p_off, l_frac[LOG_FRAC]});
    lp = (LOG_FRAC+P_W+18)'(lg) * $signed({1'b0, e});
    y  = lp[LOG_FRAC+P_W+17:EXP_FRAC];
    if (ls.zero) y = '0;
  end

  logic                x_vld  [LOG_FRAC+1];
  logic [31:0]         x_m    [LOG_FRAC+1];
  logic [LOG_FRAC-1:0] x_f    [LOG_FRAC+1];
  exp_side_t           x_side [LOG_FRAC+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      x_vld[0] <= 1'b0;
    end else if (en) begin
      x_vld[0] <= l_vld[LOG_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_m[0]         <= 32'd1 << MANT_FRAC;
      x_f[0]         <= y[LOG_FRAC-1:0];
      x_side[0].dir  <= ls.dir;
      x_side[0].kill <= ls.zero && (e != 16'd0);
      x_side[0].ip   <= 11'(y >>> LOG_FRAC);
    end
  end

  for (genvar k = 0; k < LOG_FRAC; k++) begin : g_exp
    plc_exp_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .root(ROOTS[k]),
      .vld_i(x_vld[k]), .m_i(x_m[k]), .f_i(x_f[k]), .side_i(x_side[k]),
      .vld_o(x_vld[k+1]), .m_o(x_m[k+1]), .f_o(x_f[k+1]), .side_o(x_side[k+1])
    );
  end

  // stage D: peak scale and shift amount
  exp_side_t          xs;
  logic               d_vld;
  logic [63:0]        d_v;
  logic signed [11:0] d_s;

  assign xs = x_side[LOG_FRAC];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= x_vld[LOG_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (xs.kill)     d_v <= '0;
      else if (xs.dir) d_v <= 64'(x_m[LOG_FRAC]);
      else             d_v <= 64'(x_m[LOG_FRAC]) * 64'(peak_scale);
      d_s <= 12'(xs.ip) - 12'(MANT_FRAC) + (xs.dir ? 12'(FRAC_BITS) : 12'd0);
    end
  end

  // stage E: shift and saturate
  logic [30:0] res;
  logic        sat;
  logic [11:0] neg;
  logic [63:0] sh;

  always_comb begin
    res = '0;
    sat = 1'b0;
    neg = 12'(-d_s);
    sh  = '0;
    if (d_v == '0) begin
      res = '0;
    end else if (d_s < 0) begin
      if (neg < 12'd64) begin
        sh = d_v >> neg[5:0];
        if (sh > 64'(OUT_MAX)) begin
          sat = 1'b1;
          res = OUT_MAX;
        end else begin
          res = sh[30:0];
        end
      end
    end else if (d_s >= 12'sd31) begin
      sat = 1'b1;
      res = OUT_MAX;
    end else if ((d_v >> (6'd31 - 6'(d_s))) != '0) begin
      sat = 1'b1;
      res = OUT_MAX;
    end else begin
      sh  = d_v << 6'(d_s);
      res = sh[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_out <= res;
      saturated  <= sat;
    end
  end

endmodule

### src/plc_checker.sv
// Port-level checks for the power-law transfer unit, bound to the top level.
// Depends on assert_macros.svh and plc_pkg.
`include "assert_macros.svh"

module plc_checker
  import plc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [30:0] sample_out,
  input logic        saturated
);

  `PLC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid)
  `PLC_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(sample_out))
  `PLC_ASSERT(a_sat_max, out_valid && saturated |-> sample_out == OUT_MAX)
  `PLC_ASSERT(a_ready, in_ready == (!out_valid || out_ready))

endmodule

bind power_law_transfer_unit plc_checker u_plc_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .sample_out(sample_out), .saturated(saturated)
);

### bench/tb_top.sv
// Self-checking bench for power_law_transfer_unit: forward and inverse power-law
// samples under several register settings, with random idling on both handshakes.
// Depends on plc_pkg and the unit's RTL.
module tb_top;
  import plc_pkg::*;

  localparam int LATENCY = 62;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        direction = 1'b0;
  logic [31:0] sample_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [30:0] sample_out;
  logic        saturated;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  typedef struct packed {
    logic [30:0] level;
    logic        clipped;
  } curve_out_t;

  // golden curve with its own register copy
  logic [15:0] gamma_q, inv_exp_q;
  logic [31:0] peak_q, inv_peak_q;

  function automatic logic [63:0] sqrt_floor(input logic [63:0] v);
    logic [63:0] r, b, w;
    r = '0;
    w = v;
    b = 64'd1 << 62;
    while (b > w) b = b >> 2;
    while (b != 0) begin
      if (w >= r + b) begin
        w = w - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint fshift(input longint v, input int sh);
    if (v >= 0) return v >>> sh;
    return -((-v + ((longint'(1) << sh) - 1)) >>> sh);
  endfunction

  function automatic longint log2_q28(input logic [63:0] x);
    int p;
    logic [63:0] m, fr;
    p = 63;
    fr = '0;
    while (x[p] == 1'b0) p--;
    m = (p <= MANT_FRAC) ? (x << (MANT_FRAC - p)) : (x >> (p - MANT_FRAC));
    for (int i = 0; i < LOG_FRAC; i++) begin
      m = (m * m) >> MANT_FRAC;
      if (m >= (64'd2 << MANT_FRAC)) begin
        m = m >> 1;
        fr[LOG_FRAC - 1 - i] = 1'b1;
      end
    end
    return (longint'(p) - FRAC_BITS) * (longint'(1) << LOG_FRAC) + longint'(fr);
  endfunction

  function automatic bit raise(input logic [63:0] x, input logic [15:0] e,
                               output logic [63:0] mant, output longint ip);
    longint y;
    logic [63:0] f, r, m;
    mant = '0;
    ip = 0;
    if (x == 0) begin
      if (e != 0) return 1'b0;
      mant = 64'd1 << MANT_FRAC;
      return 1'b1;
    end
    y = fshift(log2_q28(x) * longint'(e), EXP_FRAC);
    ip = fshift(y, LOG_FRAC);
    f = y - ip * (longint'(1) << LOG_FRAC);
    r = sqrt_floor(64'd1 << 61);
    m = 64'd1 << MANT_FRAC;
    for (int k = 0; k < LOG_FRAC; k++) begin
      if (f[LOG_FRAC - 1 - k]) m = (m * r) >> MANT_FRAC;
      r = sqrt_floor(r << MANT_FRAC);
    end
    mant = m;
    return 1'b1;
  endfunction

  function automatic curve_out_t clip(input logic [63:0] v, input longint s);
    curve_out_t o;
    o = '0;
    if (v == 0) return o;
    if (s < 0) begin
      if (s <= -64) return o;
      v = v >> (-s);
    end else if (s >= 31 || v > (64'h7FFF_FFFF >> s)) begin
      v = 64'hFFFF_FFFF;
    end else begin
      v = v << s;
    end
    if (v > 64'h7FFF_FFFF) begin
      o.level = OUT_MAX;
      o.clipped = 1'b1;
    end else begin
      o.level = v[30:0];
    end
    return o;
  endfunction

  function automatic curve_out_t transfer(input logic dir, input logic [31:0] raw);
    logic [63:0] x, t, mant;
    longint n;
    x = raw[31] ? 64'd0 : {32'd0, raw};
    if (dir == 1'b0) begin
      if (raise(x, gamma_q, mant, n)) return clip(mant * peak_q, n - MANT_FRAC);
    end else begin
      t = (x * inv_peak_q) >> FRAC_BITS;
      if (raise(t, inv_exp_q, mant, n)) return clip(mant, n - MANT_FRAC + FRAC_BITS);
    end
    return '0;
  endfunction

  class curve_scoreboard;
    curve_out_t pending[$];
    int errors = 0;
    int checked = 0;

    function void note_sample(curve_out_t e);
      pending.push_back(e);
    endfunction

    function void check_result(logic [30:0] lvl, logic clp);
      curve_out_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: sample_out=%h saturated=%b", lvl, clp);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (e.level !== lvl || e.clipped !== clp) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %h/%b, got %h/%b", e.level, e.clipped, lvl, clp);
      end
    endfunction
  endclass

  curve_scoreboard sb = new();

  power_law_transfer_unit dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  int send_idle = 0, recv_idle = 0, stall_cycles = 0, n_items = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (out_valid && out_ready) sb.check_result(sample_out, saturated);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send(input logic dir, input logic [31:0] s);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    direction <= dir;
    sample_in <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(transfer(dir, s));
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_GAMMA:   gamma_q = v[15:0];
      REG_INV_EXP: inv_exp_q = v[15:0];
      REG_PEAK:    peak_q = v;
      default:     inv_peak_q = v;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] g, input logic [15:0] ie,
                          input logic [31:0] pk, input logic [31:0] ipk);
    write_reg(REG_GAMMA, g);
    write_reg(REG_INV_EXP, ie);
    write_reg(REG_PEAK, pk);
    write_reg(REG_INV_PEAK, ipk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(32'h0002_0000);
      2: return 32'h1 << $urandom_range(31);
      3: return $urandom_range(32'h00FF_FFFF);
      default: return {1'b0, 31'($urandom)} >> $urandom_range(20);
    endcase
  endfunction

  task automatic random_burst(input int count);
    for (int i = 0; i < count; i++) send(1'($urandom_range(1)), rand_sample());
  endtask

  logic [31:0] corner [8] = '{32'h0, 32'h1, 32'h0001_0000, 32'h7FFF_FFFF,
                              32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_8000, 32'h0100_0000};

  initial begin
    gamma_q = 16'd9011;
    inv_exp_q = 16'd1862;
    peak_q = 32'd65536;
    inv_peak_q = 32'd65536;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: corners in both directions at reset settings
    foreach (corner[i]) begin
      send(1'b0, corner[i]);
      send(1'b1, corner[i]);
    end
    drain();
    // zero exponent, zero scale
    set_regs(16'd0, 16'd0, 32'd0, 32'd0);
    for (int i = 0; i < 4; i++) begin
      send(1'b0, corner[i]);
      send(1'b1, corner[i]);
    end
    drain();
    set_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send(i[0], corner[i + 1]);
    drain();

    send_idle = 9;
    recv_idle = 59;
    set_regs(16'd9011, 16'd1862, 32'd65536, 32'd65536);
    random_burst(300);
    drain();
    set_regs(16'd1, 16'd1, 32'd1, 32'd1);
    random_burst(150);
    drain();
    send_idle = 59;
    recv_idle = 9;
    set_regs(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
             $urandom, $urandom);
    random_burst(300);
    drain();
    send_idle = 0;
    recv_idle = 0;
    set_regs(16'd4096, 16'd4096, $urandom_range(32'h0010_0000), $urandom_range(32'h0010_0000));
    random_burst(350);
    drain();
    set_regs(16'($urandom_range(16'h3FFF)), 16'($urandom_range(16'h3FFF)),
             $urandom, $urandom);
    random_burst(320);
    drain();

    $display("covered %0d samples over several register settings, both curve directions",
             n_items);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

### power_law_transfer_unit.f
+incdir+src
src/plc_pkg.sv
src/plc_log_cell.sv
src/plc_exp_cell.sv
src/power_law_transfer_unit.sv
src/plc_checker.sv
bench/tb_top.sv
